FILE: hw/rtl/dgras_pkg.sv
// Shared types and constants for the GC-content and run constraint check.
`default_nettype none

package dgras_pkg;

    localparam int unsigned NUM_SYMS   = 32;
    localparam int unsigned SYM_W      = 2;
    localparam int unsigned HIST_W     = NUM_SYMS * SYM_W;
    localparam int unsigned LIM_W      = 6;
    localparam int unsigned GRP_SYMS   = 8;
    localparam int unsigned NUM_GRPS   = NUM_SYMS / GRP_SYMS;
    localparam int unsigned GRP_CNT_W  = 4;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 64;
    localparam int unsigned OUT_DATA_W = 16;

    typedef logic [SYM_W-1:0] t_sym;
    typedef logic [LIM_W-1:0] t_lim;

    localparam t_sym SYM_A = 2'd0;
    localparam t_sym SYM_C = 2'd1;
    localparam t_sym SYM_G = 2'd2;
    localparam t_sym SYM_T = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GC_WINDOW_MASK = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GC_HIGH_LIMIT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GC_LOW_LIMIT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RUN        = 3'd4;

    localparam t_lim RESET_GC_HIGH_LIMIT = 6'd32;
    localparam t_lim RESET_MAX_RUN       = 6'd4;
    localparam t_lim MIN_RUN             = 6'd2;

    typedef struct packed {
        t_sym       allowed_3;
        t_sym       allowed_2;
        t_sym       allowed_1;
        t_sym       allowed_0;
        logic [2:0] allowed_count;
    } t_result;

endpackage

`default_nettype wire

FILE: hw/rtl/dna_gc_run_allowed_symbols_core.sv
// Top level of the GC-content and homopolymer-run allowed-symbol check.
//
// The input stream carries one history word of 32 two-bit nucleotides per
// word, newest symbol in the low bits. For each word the output stream gives
// the number of allowed next symbols and the allowed codes in ascending order.
// The configuration channel writes the five constraint registers by index; it
// is always ready and should only be used while no words are in flight.
// The block is a four-stage pipeline: slot compare, group popcount and run
// check, count sum, then the decision into the output register. One word is
// accepted every cycle while the output side keeps taking results.
// When the receiver stalls, the stages fill up behind the output register and
// the input ready drops only once every stage holds a word; nothing is lost.
// Synchronous reset empties the pipeline and restores the register defaults.
`default_nettype none

module dna_gc_run_allowed_symbols_core (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    // history
    input  wire logic [dgras_pkg::HIST_W-1:0]       i_s_axis_tdata,
    output logic                                    o_m_axis_tvalid,
    input  wire logic                               i_m_axis_tready,
    // allowed_count, allowed_0, allowed_1, allowed_2, allowed_3, zero padding
    output logic [dgras_pkg::OUT_DATA_W-1:0]        o_m_axis_tdata,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [dgras_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [dgras_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    // Configuration registers.
    dgras_pkg::t_lim                 r_window_length;
    logic [dgras_pkg::HIST_W-1:0]    r_gc_window_mask;
    dgras_pkg::t_lim                 r_gc_high_limit;
    dgras_pkg::t_lim                 r_gc_low_limit;
    dgras_pkg::t_lim                 r_max_run;

    // Pipeline registers.
    logic                            r_v1, r_v2, r_v3, r_v4;
    logic [dgras_pkg::NUM_SYMS-1:0]  r_gc_bits1;
    logic [dgras_pkg::NUM_SYMS-1:0]  r_eq1;
    dgras_pkg::t_sym                 r_last1, r_last2, r_last3;
    logic [dgras_pkg::GRP_CNT_W-1:0] r_grp2 [dgras_pkg::NUM_GRPS];
    logic                            r_run2, r_run3;
    dgras_pkg::t_lim                 r_gc3;
    dgras_pkg::t_result              r_res4;

    logic en1, en2, en3, en4;

    logic [dgras_pkg::HIST_W-1:0]    masked;
    logic [dgras_pkg::NUM_SYMS-1:0]  n_gc_bits1;
    logic [dgras_pkg::NUM_SYMS-1:0]  n_eq1;
    logic [dgras_pkg::GRP_CNT_W-1:0] n_grp2 [dgras_pkg::NUM_GRPS];
    logic                            n_run2;
    dgras_pkg::t_lim                 run_lim;
    dgras_pkg::t_lim                 n_gc3;
    dgras_pkg::t_result              n_res4;
    logic                            cfg_wr;

    assign en4 = !r_v4 || i_m_axis_tready;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;

    assign o_s_axis_tready = en1;
    assign o_m_axis_tvalid = r_v4;
    assign o_m_axis_tdata  = {5'd0, r_res4};
    assign o_cfg_ready     = 1'b1;
    assign cfg_wr          = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length  <= '0;
            r_gc_window_mask <= '0;
            r_gc_high_limit  <= dgras_pkg::RESET_GC_HIGH_LIMIT;
            r_gc_low_limit   <= '0;
            r_max_run        <= dgras_pkg::RESET_MAX_RUN;
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                dgras_pkg::REG_WINDOW_LENGTH: begin
                    r_window_length <= i_cfg_data[dgras_pkg::LIM_W-1:0];
                end
                dgras_pkg::REG_GC_WINDOW_MASK: begin
                    r_gc_window_mask <= i_cfg_data[dgras_pkg::HIST_W-1:0];
                end
                dgras_pkg::REG_GC_HIGH_LIMIT: begin
                    r_gc_high_limit <= i_cfg_data[dgras_pkg::LIM_W-1:0];
                end
                dgras_pkg::REG_GC_LOW_LIMIT: begin
                    r_gc_low_limit <= i_cfg_data[dgras_pkg::LIM_W-1:0];
                end
                dgras_pkg::REG_MAX_RUN: begin
                    r_max_run <= i_cfg_data[dgras_pkg::LIM_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Stage 1: per-slot GC flag under the mask, and slot equality with the newest symbol.
    always_comb begin
        masked = i_s_axis_tdata & r_gc_window_mask;
        for (int i = 0; i < dgras_pkg::NUM_SYMS; i++) begin
            n_gc_bits1[i] = masked[2*i] ^ masked[2*i+1];
            n_eq1[i] = (i_s_axis_tdata[2*i +: 2] == i_s_axis_tdata[1:0]);
        end
    end

    // Stage 2: group popcounts and the run check.
    always_comb begin
        for (int g = 0; g < dgras_pkg::NUM_GRPS; g++) begin
            n_grp2[g] = '0;
            for (int b = 0; b < dgras_pkg::GRP_SYMS; b++) begin
                n_grp2[g] = n_grp2[g]
                    + dgras_pkg::GRP_CNT_W'(r_gc_bits1[g*dgras_pkg::GRP_SYMS + b]);
            end
        end
        run_lim = (r_max_run < dgras_pkg::MIN_RUN) ? dgras_pkg::MIN_RUN : r_max_run;
        n_run2 = 1'b1;
        for (int i = 1; i < dgras_pkg::NUM_SYMS; i++) begin
            if ((dgras_pkg::LIM_W'(i) < run_lim) && !r_eq1[i]) begin
                n_run2 = 1'b0;
            end
        end
        if ((run_lim > dgras_pkg::LIM_W'(dgras_pkg::NUM_SYMS))
                && (r_last1 != dgras_pkg::SYM_A)) begin
            n_run2 = 1'b0;
        end
    end

    // Stage 3: total GC count.
    always_comb begin
        n_gc3 = '0;
        for (int g = 0; g < dgras_pkg::NUM_GRPS; g++) begin
            n_gc3 = n_gc3 + dgras_pkg::LIM_W'(r_grp2[g]);
        end
    end

    // Stage 4: allowed-symbol decision.
    always_comb begin
        n_res4 = '0;
        if (r_window_length == '0) begin
            n_res4.allowed_count = 3'd4;
            n_res4.allowed_0     = dgras_pkg::SYM_A;
            n_res4.allowed_1     = dgras_pkg::SYM_C;
            n_res4.allowed_2     = dgras_pkg::SYM_G;
            n_res4.allowed_3     = dgras_pkg::SYM_T;
        end else if (r_gc3 >= r_gc_high_limit) begin
            if (r_run3 && r_last3 == dgras_pkg::SYM_A) begin
                n_res4.allowed_count = 3'd1;
                n_res4.allowed_0     = dgras_pkg::SYM_T;
            end else if (r_run3 && r_last3 == dgras_pkg::SYM_T) begin
                n_res4.allowed_count = 3'd1;
                n_res4.allowed_0     = dgras_pkg::SYM_A;
            end else begin
                n_res4.allowed_count = 3'd2;
                n_res4.allowed_0     = dgras_pkg::SYM_A;
                n_res4.allowed_1     = dgras_pkg::SYM_T;
            end
        end else if (r_gc3 <= r_gc_low_limit) begin
            if (r_run3 && r_last3 == dgras_pkg::SYM_C) begin
                n_res4.allowed_count = 3'd1;
                n_res4.allowed_0     = dgras_pkg::SYM_G;
            end else if (r_run3 && r_last3 == dgras_pkg::SYM_G) begin
                n_res4.allowed_count = 3'd1;
                n_res4.allowed_0     = dgras_pkg::SYM_C;
            end else begin
                n_res4.allowed_count = 3'd2;
                n_res4.allowed_0     = dgras_pkg::SYM_C;
                n_res4.allowed_1     = dgras_pkg::SYM_G;
            end
        end else if (r_run3) begin
            n_res4.allowed_count = 3'd3;
            n_res4.allowed_0 = (r_last3 == dgras_pkg::SYM_A) ? dgras_pkg::SYM_C
                                                             : dgras_pkg::SYM_A;
            n_res4.allowed_1 = (r_last3 == dgras_pkg::SYM_A || r_last3 == dgras_pkg::SYM_C)
                               ? dgras_pkg::SYM_G : dgras_pkg::SYM_C;
            n_res4.allowed_2 = (r_last3 == dgras_pkg::SYM_T) ? dgras_pkg::SYM_G
                                                             : dgras_pkg::SYM_T;
        end else begin
            n_res4.allowed_count = 3'd4;
            n_res4.allowed_0     = dgras_pkg::SYM_A;
            n_res4.allowed_1     = dgras_pkg::SYM_C;
            n_res4.allowed_2     = dgras_pkg::SYM_G;
            n_res4.allowed_3     = dgras_pkg::SYM_T;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_s_axis_tvalid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
            if (en4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_gc_bits1 <= n_gc_bits1;
            r_eq1      <= n_eq1;
            r_last1    <= i_s_axis_tdata[1:0];
        end
        if (en2) begin
            r_grp2  <= n_grp2;
            r_run2  <= n_run2;
            r_last2 <= r_last1;
        end
        if (en3) begin
            r_gc3   <= n_gc3;
            r_run3  <= r_run2;
            r_last3 <= r_last2;
        end
        if (en4) begin
            r_res4 <= n_res4;
        end
    end

`ifndef SYNTHESIS
    a_ready_only_when_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (r_v1 && r_v2 && r_v3 && r_v4 && !i_m_axis_tready))
        else $error("input stalled while the pipeline has room");

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (r_res4.allowed_count != 3'd0 && r_res4.allowed_count <= 3'd4))
        else $error("allowed count out of range");

    a_single_slot_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && r_res4.allowed_count == 3'd1)
            |-> (r_res4.allowed_1 == '0 && r_res4.allowed_2 == '0 && r_res4.allowed_3 == '0))
        else $error("unused result slots not zero");
`endif

endmodule

`default_nettype wire
